FILE: sv/dsas_pkg.sv
// ----------------------------------------------------------------------------
// dsas_pkg
// Shared types and constants of the damped spring angle step.
// ----------------------------------------------------------------------------
package dsas_pkg;

	localparam int unsigned AXES = 3;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PITCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_YAW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ROLL  = 3'd6;

	localparam logic [31:0] STIFFNESS_RST = 32'd655360;
	localparam logic [31:0] DAMPING_RST   = 32'd65536;
	localparam logic [31:0] MASS_RST      = 32'd65536;
	localparam logic [15:0] MAX_STEP_RST  = 16'hFFFF;

	// Acceleration saturates at +-(2^47 - 1) in Q16.16.
	localparam logic [46:0] ACC_MAG_MAX = {47{1'b1}};

	typedef struct packed {
		logic [31:0] stiffness;
		logic [31:0] damping;
		logic [31:0] mass;
	} lane_cfg_t;

	typedef struct packed {
		logic start;
		logic [15:0] dt;
	} lane_ctl_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0] data;
	} cfg_word_t;

	typedef struct packed {
		logic signed [31:0] cur_pitch;
		logic signed [31:0] cur_yaw;
		logic signed [31:0] cur_roll;
		logic signed [31:0] tgt_pitch;
		logic signed [31:0] tgt_yaw;
		logic signed [31:0] tgt_roll;
		logic [15:0] step_time;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] next_pitch;
		logic signed [31:0] next_yaw;
		logic signed [31:0] next_roll;
	} out_word_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

FILE: sv/dsas_if.sv
// ----------------------------------------------------------------------------
// dsas_in_if / dsas_out_if / dsas_cfg_if
// Valid/ready channels of the damped spring angle step.
// ----------------------------------------------------------------------------
interface dsas_in_if;
	logic valid;
	logic ready;
	dsas_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsas_out_if;
	logic valid;
	logic ready;
	dsas_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsas_cfg_if;
	logic valid;
	logic ready;
	dsas_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dsas_div.sv
// ----------------------------------------------------------------------------
// dsas_div
// Restoring divider, one quotient bit per cycle, for (mag << 16) / m.
// ----------------------------------------------------------------------------
module dsas_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [64:0] quotient
);
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[64]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd65;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[63:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[64]};
				quo_q <= {quo_q[63:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: sv/dsas_lane.sv
// ----------------------------------------------------------------------------
// dsas_lane
// One axis: spring and damping terms, division by mass, velocity update
// and the unclamped next angle. Holds the axis velocity.
// ----------------------------------------------------------------------------
module dsas_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  dsas_pkg::lane_cfg_t cfg,
	input  dsas_pkg::lane_ctl_t ctl,
	input  logic signed [31:0]  cur,
	input  logic signed [31:0]  tgt,
	output logic                done,
	output logic signed [31:0]  nxt
);
	typedef enum logic [2:0] {
		L_IDLE, L_MUL, L_NUM, L_DIV, L_VEL1, L_VEL2, L_POS1, L_POS2
	} lstate_t;

	lstate_t             state_q;
	logic signed [31:0]  vel_q;
	logic signed [31:0]  cur_q;
	logic [15:0]         dt_q;
	logic [32:0]         diff_mag_q;
	logic                diff_neg_q;
	logic [31:0]         vel_mag_q;
	logic                vel_neg_q;
	logic [64:0]         sp_prod_q;
	logic [63:0]         dm_prod_q;
	logic                num_neg_q;
	logic [47:0]         acc_mag_q;
	logic                acc_neg_q;
	logic [63:0]         prod_q;
	logic                div_start;
	logic                div_done;
	logic [64:0]         div_quo;
	logic [31:0]         msor;
	logic signed [65:0]  spring, dampt, numv;
	logic [48:0]         num_abs;
	logic [48:0]         sp_t;
	logic [47:0]         dm_t;
	logic signed [63:0]  dv, sum;
	logic signed [31:0]  vnew;

	assign msor = (cfg.mass == 32'd0) ? 32'd1 : cfg.mass;

	// The divider loads the magnitude of the numerator as it is formed.
	dsas_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({num_abs, 16'd0}), .divisor(msor),
		.done(div_done), .quotient(div_quo)
	);

	assign sp_t   = sp_prod_q[64:16];
	assign dm_t   = dm_prod_q[63:16];
	assign spring = diff_neg_q ? -$signed({17'd0, sp_t}) : $signed({17'd0, sp_t});
	assign dampt  = vel_neg_q ? -$signed({18'd0, dm_t}) : $signed({18'd0, dm_t});
	assign numv   = spring - dampt;
	assign num_abs = (numv < 0) ? 49'(-numv) : 49'(numv);
	assign div_start = (state_q == L_NUM);
	assign dv  = acc_neg_q ? -$signed({16'd0, prod_q[63:16]}) : $signed({16'd0, prod_q[63:16]});
	assign vnew = dsas_pkg::sat32(64'(vel_q) + dv);
	assign sum = 64'(cur_q) + (vel_neg_q ? -$signed({16'd0, prod_q[63:16]})
		: $signed({16'd0, prod_q[63:16]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			vel_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				L_IDLE: if (ctl.start) state_q <= L_MUL;
				L_MUL:  state_q <= L_NUM;
				L_NUM:  state_q <= L_DIV;
				L_DIV:  if (div_done) state_q <= L_VEL1;
				L_VEL1: state_q <= L_VEL2;
				L_VEL2: begin
					vel_q   <= vnew;
					state_q <= L_POS1;
				end
				L_POS1: state_q <= L_POS2;
				L_POS2: begin
					done    <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: if (ctl.start) begin
				cur_q      <= cur;
				dt_q       <= ctl.dt;
				diff_mag_q <= (tgt < cur) ? 33'(cur) - 33'(tgt) : 33'(tgt) - 33'(cur);
				diff_neg_q <= tgt < cur;
				vel_neg_q  <= vel_q[31];
				vel_mag_q  <= vel_q[31] ? 32'(-vel_q) : vel_q;
			end
			L_MUL: begin
				sp_prod_q <= diff_mag_q * cfg.stiffness;
				dm_prod_q <= vel_mag_q * cfg.damping;
			end
			L_NUM: num_neg_q <= numv < 0;
			L_DIV: if (div_done) begin
				acc_neg_q <= num_neg_q;
				acc_mag_q <= (div_quo[64:47] != '0) ? {1'b0, dsas_pkg::ACC_MAG_MAX}
					: div_quo[47:0];
			end
			L_VEL1: prod_q <= acc_mag_q * dt_q;
			L_VEL2: begin
				vel_neg_q <= vnew[31];
				vel_mag_q <= vnew[31] ? 32'(-vnew) : vnew;
			end
			L_POS1: prod_q <= {16'd0, 48'(vel_mag_q * dt_q)};
			L_POS2: nxt <= dsas_pkg::sat32(sum);
			default: ;
		endcase
	end
endmodule

FILE: sv/damped_spring_angle_step.sv
// ----------------------------------------------------------------------------
// damped_spring_angle_step
// Semi-implicit Euler spring-damper for pitch, yaw and roll, Q16.16.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  in_ch   | sink      | three current angles, three targets, step time
//  out_ch  | source    | three next angles
//  cfg_ch  | sink      | register index and write data
//
// The result word is offered once all three lanes are done: the three
// lanes run together, each dominated by its bit-serial divider by the
// mass. Reset clears the velocities and loads the register defaults.
// A new word is taken once the lanes are idle and the output register
// is free; an output stall delays it.
module damped_spring_angle_step (
	input logic clk,
	input logic arst_n,
	dsas_in_if.sink    in_ch,
	dsas_out_if.source out_ch,
	dsas_cfg_if.sink   cfg_ch
);
	dsas_pkg::lane_cfg_t lcfg_q;
	logic [15:0] max_step_q;
	logic [30:0] lim_q [dsas_pkg::AXES];
	logic        busy_q;
	dsas_pkg::lane_ctl_t ctl;
	logic [2:0]  done;
	logic [2:0]  got_q;
	logic signed [31:0] cur [dsas_pkg::AXES];
	logic signed [31:0] tgt [dsas_pkg::AXES];
	logic signed [31:0] nxt [dsas_pkg::AXES];
	logic signed [31:0] res_q [dsas_pkg::AXES];
	logic signed [31:0] cl [dsas_pkg::AXES];
	logic clamp_en;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !busy_q && !out_ch.valid;
	assign ctl.start    = in_ch.valid && in_ch.ready;
	assign ctl.dt = (in_ch.data.step_time > max_step_q) ? max_step_q : in_ch.data.step_time;

	assign cur[0] = in_ch.data.cur_pitch;
	assign cur[1] = in_ch.data.cur_yaw;
	assign cur[2] = in_ch.data.cur_roll;
	assign tgt[0] = in_ch.data.tgt_pitch;
	assign tgt[1] = in_ch.data.tgt_yaw;
	assign tgt[2] = in_ch.data.tgt_roll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcfg_q.stiffness <= dsas_pkg::STIFFNESS_RST;
			lcfg_q.damping   <= dsas_pkg::DAMPING_RST;
			lcfg_q.mass      <= dsas_pkg::MASS_RST;
			max_step_q       <= dsas_pkg::MAX_STEP_RST;
			lim_q[0] <= '0;
			lim_q[1] <= '0;
			lim_q[2] <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.data.index)
				dsas_pkg::REG_STIFFNESS:   lcfg_q.stiffness <= cfg_ch.data.data;
				dsas_pkg::REG_DAMPING:     lcfg_q.damping <= cfg_ch.data.data;
				dsas_pkg::REG_MASS:        lcfg_q.mass <= cfg_ch.data.data;
				dsas_pkg::REG_MAX_STEP:    max_step_q <= cfg_ch.data.data[15:0];
				dsas_pkg::REG_LIMIT_PITCH: lim_q[0] <= cfg_ch.data.data[30:0];
				dsas_pkg::REG_LIMIT_YAW:   lim_q[1] <= cfg_ch.data.data[30:0];
				dsas_pkg::REG_LIMIT_ROLL:  lim_q[2] <= cfg_ch.data.data[30:0];
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < dsas_pkg::AXES; g++) begin : g_lane
		dsas_lane u_lane (
			.clk(clk), .arst_n(arst_n), .cfg(lcfg_q), .ctl(ctl),
			.cur(cur[g]), .tgt(tgt[g]), .done(done[g]), .nxt(nxt[g])
		);
		// Merge stage: clamp to the axis limit when any limit is set.
		always_comb begin
			cl[g] = nxt[g];
			if (clamp_en) begin
				if (nxt[g] > $signed({1'b0, lim_q[g]}))
					cl[g] = {1'b0, lim_q[g]};
				else if (nxt[g] < -$signed({1'b0, lim_q[g]}))
					cl[g] = -$signed({1'b0, lim_q[g]});
			end
		end
		always_ff @(posedge clk) begin
			if (done[g])
				res_q[g] <= cl[g];
		end
	end

	assign clamp_en = (lim_q[0] | lim_q[1] | lim_q[2]) != '0;

	// The lanes run in lockstep, so all finish in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			out_ch.valid <= 1'b0;
			got_q        <= '0;
		end else begin
			got_q <= done;
			if (ctl.start)
				busy_q <= 1'b1;
			else if (&done)
				busy_q <= 1'b0;
			if (&done)
				out_ch.valid <= 1'b1;
			else if (out_ch.ready)
				out_ch.valid <= 1'b0;
		end
	end

	assign out_ch.data.next_pitch = res_q[0];
	assign out_ch.data.next_yaw   = res_q[1];
	assign out_ch.data.next_roll  = res_q[2];

	// A word is never accepted while one is being worked on.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("accept while busy");
	// Lanes finish together.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(done != 3'b000) |-> (done == 3'b111)) else $error("lanes out of step");
	// Completion raises the output valid.
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(got_q == 3'b111) |-> out_ch.valid) else $error("result lost");
endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped spring angle step. A predictor inside
// the bench keeps its own copy of the register set and the per-axis
// velocities. It works out the next angles for every word accepted on the
// input channel. A checker compares each output word field by field with
// the oldest prediction. Directed tests come first, then randomised phases
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_LIMIT = 64'sh7FFFFFFFFFFF;
	localparam int unsigned RUN_LIMIT = 2000000;
	localparam int unsigned SETTLE_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsas_in_if in_ch ();
	dsas_out_if out_ch ();
	dsas_cfg_if cfg_ch ();

	damped_spring_angle_step i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// The clock has a period of 2 ns.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the register set and of the stored velocities.
	logic [31:0] spring_k;
	logic [31:0] damp_k;
	logic [31:0] mass_k;
	logic [15:0] step_cap;
	logic [30:0] angle_limit [dsas_pkg::AXES];
	longint axis_vel [dsas_pkg::AXES];

	dsas_pkg::out_word_t next_angles_q [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit steady = 1'b0;	// while set, neither side idles

	// The cycle counter ends the run if the block stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// A product with an unsigned Q16.16 factor, truncated towards zero.
	function automatic longint scale_q16(longint a, logic [31:0] b);
		logic [63:0] mag;
		logic [63:0] p;
		mag = (a < 0) ? -a : a;
		p = mag * b[31:16] + ((mag * b[15:0]) >> 16);
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	// The division by the mass, truncated towards zero and saturated.
	function automatic longint divide_by_mass(longint num, logic [31:0] m);
		logic [63:0] mag;
		logic [63:0] q1;
		logic [63:0] r;
		longint res;
		mag = (num < 0) ? -num : num;
		q1 = mag / m;
		r = mag % m;
		if (q1 >= 64'h80000000)
			res = ACC_LIMIT;
		else
			res = longint'((q1 << 16) + ((r << 16) / m));
		return (num < 0) ? -res : res;
	endfunction

	function automatic longint clip_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Advances the shadow velocities by one word and returns the next angles.
	function automatic dsas_pkg::out_word_t spring_step(dsas_pkg::in_word_t w);
		longint cur [dsas_pkg::AXES];
		longint tgt [dsas_pkg::AXES];
		longint nxt [dsas_pkg::AXES];
		longint num;
		longint acc;
		longint lim;
		logic [31:0] dt;
		logic [31:0] m;
		bit clamp_on;
		dsas_pkg::out_word_t r;
		cur[0] = w.cur_pitch;
		cur[1] = w.cur_yaw;
		cur[2] = w.cur_roll;
		tgt[0] = w.tgt_pitch;
		tgt[1] = w.tgt_yaw;
		tgt[2] = w.tgt_roll;
		dt = (w.step_time > step_cap) ? step_cap : w.step_time;
		m = (mass_k == 0) ? 32'd1 : mass_k;
		clamp_on = (angle_limit[0] | angle_limit[1] | angle_limit[2]) != 0;
		for (int i = 0; i < dsas_pkg::AXES; i++) begin
			num = scale_q16(tgt[i] - cur[i], spring_k) - scale_q16(axis_vel[i], damp_k);
			acc = divide_by_mass(num, m);
			axis_vel[i] = clip_s32(axis_vel[i] + scale_q16(acc, dt));
			nxt[i] = clip_s32(cur[i] + scale_q16(axis_vel[i], dt));
			if (clamp_on) begin
				lim = angle_limit[i];
				if (nxt[i] > lim)
					nxt[i] = lim;
				if (nxt[i] < -lim)
					nxt[i] = -lim;
			end
		end
		r.next_pitch = nxt[0][31:0];
		r.next_yaw = nxt[1][31:0];
		r.next_roll = nxt[2][31:0];
		return r;
	endfunction

	// Output side: random back-pressure and the check of every word.
	always @(posedge clk) begin
		dsas_pkg::out_word_t exp_w;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (next_angles_q.size() == 0) begin
					$error("next angles word with no prediction waiting");
					fail_count++;
				end else begin
					exp_w = next_angles_q.pop_front();
					if (out_ch.data.next_pitch !== exp_w.next_pitch) begin
						$error("next_pitch: expected %0d, got %0d", exp_w.next_pitch,
							out_ch.data.next_pitch);
						fail_count++;
					end
					if (out_ch.data.next_yaw !== exp_w.next_yaw) begin
						$error("next_yaw: expected %0d, got %0d", exp_w.next_yaw,
							out_ch.data.next_yaw);
						fail_count++;
					end
					if (out_ch.data.next_roll !== exp_w.next_roll) begin
						$error("next_roll: expected %0d, got %0d", exp_w.next_roll,
							out_ch.data.next_roll);
						fail_count++;
					end
				end
			end
			out_ch.ready <= steady || ($urandom_range(99) >= 38);
		end
	end

	// Writes one register and mirrors it in the shadow set.
	task automatic write_reg(logic [dsas_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data.index <= idx;
		cfg_ch.data.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			dsas_pkg::REG_STIFFNESS: spring_k = value;
			dsas_pkg::REG_DAMPING: damp_k = value;
			dsas_pkg::REG_MASS: mass_k = value;
			dsas_pkg::REG_MAX_STEP: step_cap = value[15:0];
			dsas_pkg::REG_LIMIT_PITCH: angle_limit[0] = value[30:0];
			dsas_pkg::REG_LIMIT_YAW: angle_limit[1] = value[30:0];
			dsas_pkg::REG_LIMIT_ROLL: angle_limit[2] = value[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] k, logic [31:0] d, logic [31:0] m,
			logic [15:0] cap, logic [31:0] lp, logic [31:0] ly, logic [31:0] lr);
		write_reg(dsas_pkg::REG_STIFFNESS, k);
		write_reg(dsas_pkg::REG_DAMPING, d);
		write_reg(dsas_pkg::REG_MASS, m);
		write_reg(dsas_pkg::REG_MAX_STEP, {16'd0, cap});
		write_reg(dsas_pkg::REG_LIMIT_PITCH, lp);
		write_reg(dsas_pkg::REG_LIMIT_YAW, ly);
		write_reg(dsas_pkg::REG_LIMIT_ROLL, lr);
	endtask

	// Sends one word. Valid is only lowered while idling, so that a word
	// following straight after never sees valid dropped and raised at once.
	task automatic send_word(dsas_pkg::in_word_t w);
		while (!steady && $urandom_range(99) < 38) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		next_angles_q.push_back(spring_step(w));
	endtask

	// Waits until every predicted word has come back, then lets the lanes
	// settle so that the block is idle before any register write.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (next_angles_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1, 0) ? 32'h7FFFFFFF - $urandom_range(255)
				: 32'h80000000 + $urandom_range(255);
			default: return $signed($urandom_range(20000000)) - 32'sd10000000;
		endcase
	endfunction

	function automatic dsas_pkg::in_word_t rand_word();
		dsas_pkg::in_word_t w;
		w.cur_pitch = rand_angle();
		w.cur_yaw = rand_angle();
		w.cur_roll = rand_angle();
		// Targets mostly close to the current angle, sometimes anywhere.
		w.tgt_pitch = ($urandom_range(3) == 0) ? rand_angle()
			: w.cur_pitch + $signed($urandom_range(2000000)) - 32'sd1000000;
		w.tgt_yaw = ($urandom_range(3) == 0) ? rand_angle()
			: w.cur_yaw + $signed($urandom_range(2000000)) - 32'sd1000000;
		w.tgt_roll = ($urandom_range(3) == 0) ? rand_angle()
			: w.cur_roll + $signed($urandom_range(2000000)) - 32'sd1000000;
		case ($urandom_range(3))
			0: w.step_time = 16'($urandom);
			1: w.step_time = 16'(16'hFFFF - $urandom_range(15));
			default: w.step_time = 16'($urandom_range(2000));
		endcase
		return w;
	endfunction

	function automatic dsas_pkg::in_word_t make_word(logic [31:0] c, logic [31:0] t,
			logic [15:0] dt);
		dsas_pkg::in_word_t w;
		w.cur_pitch = c;
		w.cur_yaw = -c;
		w.cur_roll = c ^ 32'h0000FFFF;
		w.tgt_pitch = t;
		w.tgt_yaw = ~t;
		w.tgt_roll = t >>> 1;
		w.step_time = dt;
		return w;
	endfunction

	// Directed words at the reset register values: extremes of the angles
	// and of the step time, where the velocities run into saturation.
	task automatic test_field_extremes();
		send_word(make_word(32'd0, 32'd0, 16'd0));
		send_word(make_word(32'd0, 32'h00010000, 16'd1));
		send_word(make_word(32'h7FFFFFFF, 32'h80000000, 16'hFFFF));
		send_word(make_word(32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
		send_word(make_word(32'h80000000, 32'h80000000, 16'h8000));
		send_word(make_word(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
		send_word(make_word(32'h00050000, 32'hFFFB0000, 16'h0400));
		drain();
	endtask

	// Mass of zero acts as one LSB; tiny mass drives the acceleration into
	// saturation; the time step cap limits dt.
	task automatic test_mass_and_step_cap();
		write_all(32'hFFFFFFFF, 32'd0, 32'd0, 16'h0100, 32'd0, 32'd0, 32'd0);
		send_word(make_word(32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
		send_word(make_word(32'd0, 32'h00000001, 16'h00FF));
		drain();
		write_reg(dsas_pkg::REG_MASS, 32'd1);
		send_word(make_word(32'h00100000, 32'hFFF00000, 16'h0200));
		drain();
		write_reg(dsas_pkg::REG_MAX_STEP, 32'd0);
		send_word(make_word(32'h12345678, 32'h87654321, 16'hFFFF));
		drain();
		write_all(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'd0, 32'd0, 32'd0);
		send_word(make_word(32'h40000000, 32'hC0000000, 16'hFFFF));
		send_word(make_word(32'h00000000, 32'h00000000, 16'h8000));
		drain();
	endtask

	// Clamping, including an axis with a zero limit while another is set,
	// and writes of the full 32 bits into the 31-bit limit registers.
	task automatic test_angle_clamp();
		write_all(dsas_pkg::STIFFNESS_RST, dsas_pkg::DAMPING_RST, dsas_pkg::MASS_RST,
			dsas_pkg::MAX_STEP_RST, 32'h00050000, 32'd0, 32'hFFFFFFFF);
		send_word(make_word(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
		send_word(make_word(32'h80000000, 32'h80000000, 16'hFFFF));
		send_word(make_word(32'h00020000, 32'hFFFE0000, 16'h1000));
		drain();
		write_all(dsas_pkg::STIFFNESS_RST, dsas_pkg::DAMPING_RST, dsas_pkg::MASS_RST,
			dsas_pkg::MAX_STEP_RST, 32'd1, 32'h7FFFFFFF, 32'd1);
		send_word(make_word(32'h00030000, 32'hFFFD0000, 16'h2000));
		send_word(make_word(32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
		drain();
	endtask

	// Random phases under varied register settings. One phase runs with no
	// idling at all; between phases the sender waits for every result.
	task automatic test_random_phases();
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 0)
				write_all(dsas_pkg::STIFFNESS_RST, dsas_pkg::DAMPING_RST,
					dsas_pkg::MASS_RST, dsas_pkg::MAX_STEP_RST, 32'd0, 32'd0, 32'd0);
			else
				write_all($urandom_range(3) == 0 ? $urandom : $urandom_range(1048576),
					$urandom_range(3) == 0 ? $urandom : $urandom_range(262144),
					$urandom_range(4) == 0 ? $urandom_range(3) : $urandom_range(1, 1048576),
					16'($urandom), ($urandom_range(1)) ? $urandom : 32'd0,
					($urandom_range(1)) ? $urandom : 32'd0,
					($urandom_range(1)) ? $urandom : 32'd0);
			steady = (ph == 3);
			for (int n = 0; n < 120; n++)
				send_word(rand_word());
			drain();
			steady = 1'b0;
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		spring_k = dsas_pkg::STIFFNESS_RST;
		damp_k = dsas_pkg::DAMPING_RST;
		mass_k = dsas_pkg::MASS_RST;
		step_cap = dsas_pkg::MAX_STEP_RST;
		for (int i = 0; i < dsas_pkg::AXES; i++) begin
			angle_limit[i] = '0;
			axis_vel[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_mass_and_step_cap();
		test_angle_clamp();
		test_random_phases();

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: damped_spring_angle_step.f
sv/dsas_pkg.sv
sv/dsas_if.sv
sv/dsas_div.sv
sv/dsas_lane.sv
sv/damped_spring_angle_step.sv
verif/tb_top.sv
